// ----- design/ntc_pkg.sv -----
// Shared types and constants for the NTC thermistor temperature converter
`default_nettype none

package ntc_pkg;

    localparam int TEMP_FRAC_BITS_DEF = 4;
    localparam int GUARD_BITS         = 6;

    localparam int LOG_FB    = 30;
    localparam int LOG_IN_W  = 33;
    localparam int LOG_EXP_W = 6;
    localparam int LOG_OUT_W = LOG_EXP_W + LOG_FB;
    localparam int LOG_LAT   = LOG_FB + 2;

    localparam int MUL_LAT = 4;
    localparam int X_W     = 36;
    localparam int Y_W     = 64;
    localparam int COEF_W  = 48;
    localparam int OHM_W   = 20;
    localparam int MV_W    = 13;
    localparam int TEMP_W  = 13;

    localparam int DIV_BITS = 41;
    localparam int DIV_W    = 63;

    localparam logic signed [X_W-1:0]   LN2_Q30 = 36'sd744261118;
    localparam logic signed [Y_W-1:0]   SAT_POS = 64'sh4000_0000_0000_0000;
    localparam logic signed [Y_W-1:0]   SAT_NEG = -SAT_POS;
    localparam logic signed [Y_W-1:0]   INV_MIN = 64'sd282;
    localparam logic [DIV_BITS-1:0]     T_LIMIT = 41'h100_0000_0000;

    typedef enum logic [2:0] {
        REG_PULLUP  = 3'd0,
        REG_NOMINAL = 3'd1,
        REG_COEF_A  = 3'd2,
        REG_COEF_B  = 3'd3,
        REG_COEF_C  = 3'd4,
        REG_COEF_D  = 3'd5,
        REG_MARGIN  = 3'd6,
        REG_DISC    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] sense_mv;
        logic [12:0]        vref_mv;
    } sample_t;

    typedef struct packed {
        logic signed [12:0] temperature_q4;
        logic               open_sensor;
    } result_t;

    typedef struct packed {
        logic valid;
        logic open;
    } ctl_t;

endpackage

`default_nettype wire

// ----- design/ntc_thermistor_to_temperature_unit.sv -----
// Top level: NTC divider reading to Celsius via fixed-point Steinhart-Hart
//
// Input beats arrive on sample and are taken when start is high (busy stays
// low: the datapath is a fixed pipeline and never refuses a beat). Each beat
// yields exactly one result beat on result, marked by result_strobe for one
// cycle; the receiver has no back-pressure.
// Throughput is one beat per cycle. The pipeline runs through the two
// 32-stage log units (one squaring per fraction bit), four 4-stage
// multiply/saturate units and the 41-stage restoring divider that forms
// T = 2^(54+F)/y. Registers are written via wr_en/wr_index/wr_data; the
// user must write them only while no beat is in flight; the block does not
// check. Reset loads the register defaults and clears all in-flight valid
// bits; no results appear until new beats are taken.
`default_nettype none

module ntc_thermistor_to_temperature_unit #(
    parameter int TEMP_FRAC_BITS = ntc_pkg::TEMP_FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire ntc_pkg::sample_t             sample,
    output logic                              result_strobe,
    output ntc_pkg::result_t                  result,
    input  wire logic                         wr_en,
    input  wire ntc_pkg::reg_index_t          wr_index,
    input  wire logic [ntc_pkg::COEF_W-1:0]   wr_data
);

    localparam int PIPE_DEPTH = 2 + ntc_pkg::LOG_LAT + 1 + 4 * ntc_pkg::MUL_LAT + 2
                              + ntc_pkg::DIV_BITS + 4;
    localparam int DW  = ntc_pkg::DIV_W;
    localparam int DB  = ntc_pkg::DIV_BITS;
    localparam int MV  = ntc_pkg::MV_W;
    localparam int NW  = ntc_pkg::LOG_IN_W;
    localparam int VW  = 49;
    localparam logic [DW-1:0] T_NUM =
        DW'(1) << (48 + TEMP_FRAC_BITS + ntc_pkg::GUARD_BITS);
    localparam logic signed [VW-1:0] C_BIAS =
        (VW'(27315) << (TEMP_FRAC_BITS + ntc_pkg::GUARD_BITS)) - VW'(3200);
    localparam logic signed [VW-1:0] W_MAX = VW'(102399);
    localparam logic signed [VW-1:0] W_MIN = -VW'(102400);

    // configuration
    logic [ntc_pkg::OHM_W-1:0]          pullup_reg, nominal_reg;
    logic signed [ntc_pkg::COEF_W-1:0]  coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [MV-1:0]                      margin_reg;
    logic signed [ntc_pkg::TEMP_W-1:0]  disc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pullup_reg  <= ntc_pkg::OHM_W'(10000);
            nominal_reg <= ntc_pkg::OHM_W'(10000);
            coef_a_reg  <= '0;
            coef_b_reg  <= '0;
            coef_c_reg  <= '0;
            coef_d_reg  <= '0;
            margin_reg  <= MV'(100);
            disc_reg    <= -ntc_pkg::TEMP_W'(4096);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ntc_pkg::REG_PULLUP:  pullup_reg  <= wr_data[ntc_pkg::OHM_W-1:0];
                ntc_pkg::REG_NOMINAL: nominal_reg <= wr_data[ntc_pkg::OHM_W-1:0];
                ntc_pkg::REG_COEF_A:  coef_a_reg  <= $signed(wr_data);
                ntc_pkg::REG_COEF_B:  coef_b_reg  <= $signed(wr_data);
                ntc_pkg::REG_COEF_C:  coef_c_reg  <= $signed(wr_data);
                ntc_pkg::REG_COEF_D:  coef_d_reg  <= $signed(wr_data);
                ntc_pkg::REG_MARGIN:  margin_reg  <= wr_data[MV-1:0];
                ntc_pkg::REG_DISC:    disc_reg    <= $signed(wr_data[ntc_pkg::TEMP_W-1:0]);
            endcase
        end
    end

    assign busy = 1'b0;

    // control shift line
    ntc_pkg::ctl_t ctl_reg [0:PIPE_DEPTH-1];
    ntc_pkg::ctl_t ctl_next;

    logic signed [16:0] s_x, thr_x;

    always_comb
    begin
        s_x            = 17'(sample.sense_mv);
        thr_x          = $signed(17'(sample.vref_mv)) - $signed(17'(margin_reg));
        ctl_next.valid = start;
        ctl_next.open  = (s_x <= 17'sd0) || (s_x >= thr_x)
                       || (pullup_reg == '0) || (nominal_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_next;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // divider terms
    logic [MV-1:0] s_reg, diff_reg;
    logic [NW-1:0] num_reg, den_reg;

    always_ff @(posedge clk)
    begin
        s_reg    <= sample.sense_mv[MV-1:0];
        diff_reg <= sample.vref_mv - sample.sense_mv[MV-1:0];
        num_reg  <= NW'(pullup_reg) * NW'(s_reg);
        den_reg  <= NW'(diff_reg) * NW'(nominal_reg);
    end

    logic [ntc_pkg::LOG_OUT_W-1:0] lg_num, lg_den;

    ntc_log2 u_log_num (
        .clk (clk),
        .v   (num_reg),
        .lg  (lg_num)
    );

    ntc_log2 u_log_den (
        .clk (clk),
        .v   (den_reg),
        .lg  (lg_den)
    );

    logic signed [ntc_pkg::LOG_OUT_W:0] l_reg;

    always_ff @(posedge clk)
    begin
        l_reg <= $signed({1'b0, lg_num}) - $signed({1'b0, lg_den});
    end

    // x = ln(R/R25), then Horner in Q48
    logic signed [ntc_pkg::Y_W-1:0] x_full, y1, y2, y3;
    logic signed [ntc_pkg::X_W-1:0] bx1, bx2;

    ntc_mulsh u_mul_ln (
        .clk    (clk),
        .a      (ntc_pkg::Y_W'(l_reg)),
        .b      (ntc_pkg::LN2_Q30),
        .addend ('0),
        .y      (x_full),
        .b_out  ()
    );

    ntc_mulsh u_mul_d (
        .clk    (clk),
        .a      (ntc_pkg::Y_W'(coef_d_reg)),
        .b      (x_full[ntc_pkg::X_W-1:0]),
        .addend (coef_c_reg),
        .y      (y1),
        .b_out  (bx1)
    );

    ntc_mulsh u_mul_c (
        .clk    (clk),
        .a      (y1),
        .b      (bx1),
        .addend (coef_b_reg),
        .y      (y2),
        .b_out  (bx2)
    );

    ntc_mulsh u_mul_b (
        .clk    (clk),
        .a      (y2),
        .b      (bx2),
        .addend (coef_a_reg),
        .y      (y3),
        .b_out  ()
    );

    // clamp 1/T and form rounded dividend
    logic [DW-1:0] yc_reg, n_reg;
    logic [DW-1:0] yc_next;

    assign yc_next = (y3 < ntc_pkg::INV_MIN) ? DW'(ntc_pkg::INV_MIN) : y3[DW-1:0];

    always_ff @(posedge clk)
    begin
        yc_reg <= yc_next;
        n_reg  <= T_NUM + (yc_next >> 1);
    end

    // restoring divider, one quotient bit per stage
    logic [DW-1:0] div_rem_reg [0:DB];
    logic [DW-1:0] div_y_reg   [0:DB];
    logic [DB-1:0] div_q_reg   [0:DB];
    logic          div_ovf_reg [0:DB];

    always_ff @(posedge clk)
    begin
        div_rem_reg[0] <= n_reg;
        div_y_reg[0]   <= yc_reg;
        div_q_reg[0]   <= '0;
        div_ovf_reg[0] <= (n_reg >> DB) >= yc_reg;
    end

    for (genvar k = 0; k < DB; k++) begin : g_div
        localparam int BIT = DB - 1 - k;
        logic take;

        assign take = (div_rem_reg[k] >> BIT) >= div_y_reg[k];

        always_ff @(posedge clk)
        begin
            div_rem_reg[k+1] <= take ? div_rem_reg[k] - (div_y_reg[k] << BIT)
                                     : div_rem_reg[k];
            div_y_reg[k+1]   <= div_y_reg[k];
            div_q_reg[k+1]   <= {div_q_reg[k][DB-2:0], take};
            div_ovf_reg[k+1] <= div_ovf_reg[k];
        end
    end

    // kelvin to Celsius, round and saturate
    logic [DB-1:0]          t_val;
    logic signed [VW-1:0]   v_reg, w_val;
    logic [17:0]            u_reg, u3_reg;
    logic [30:0]            p_val;
    logic [13:0]            q0_reg, q_val;
    logic signed [19:0]     rem_val;
    logic signed [ntc_pkg::TEMP_W-1:0] temp_val;
    ntc_pkg::result_t       result_reg;

    assign t_val = (div_ovf_reg[DB] || div_q_reg[DB] > ntc_pkg::T_LIMIT)
                 ? ntc_pkg::T_LIMIT : div_q_reg[DB];
    assign w_val = v_reg >>> 8;
    assign p_val = 31'(u_reg) * 31'd5243;
    assign rem_val = $signed(20'(u3_reg)) - $signed(20'(q0_reg) * 20'd25);
    assign q_val = rem_val[19] ? q0_reg - 14'd1 : q0_reg;
    assign temp_val = ntc_pkg::TEMP_W'(q_val - 14'd4096);

    always_ff @(posedge clk)
    begin
        v_reg <= $signed(VW'(t_val) * VW'(100)) - C_BIAS;
        priority if (w_val > W_MAX)
        begin
            u_reg <= 18'(W_MAX - W_MIN);
        end
        else if (w_val < W_MIN)
        begin
            u_reg <= '0;
        end
        else
        begin
            u_reg <= 18'(w_val - W_MIN);
        end
        q0_reg <= p_val[30:17];
        u3_reg <= u_reg;
        result_reg.open_sensor    <= ctl_reg[PIPE_DEPTH-2].open;
        result_reg.temperature_q4 <= ctl_reg[PIPE_DEPTH-2].open ? disc_reg : temp_val;
    end

    assign result        = result_reg;
    assign result_strobe = ctl_reg[PIPE_DEPTH-1].valid;

endmodule

`default_nettype wire

// ----- design/ntc_log2.sv -----
// Pipelined base-2 logarithm in Q30 by repeated squaring, one fraction bit per stage
`default_nettype none

module ntc_log2 (
    input  wire logic                          clk,
    input  wire logic [ntc_pkg::LOG_IN_W-1:0]  v,
    output logic      [ntc_pkg::LOG_OUT_W-1:0] lg
);

    localparam int FB  = ntc_pkg::LOG_FB;
    localparam int EW  = ntc_pkg::LOG_EXP_W;
    localparam int MW  = FB + 1;
    localparam int WW  = 2 * MW + 1;

    logic [EW-1:0]                 e_next;
    logic [EW-1:0]                 e_a_reg;
    logic [ntc_pkg::LOG_IN_W-1:0]  v_a_reg;
    logic [WW-1:0]                 v_wide;

    logic [MW-1:0] m_reg [0:FB];
    logic [EW-1:0] e_reg [0:FB];
    logic [FB-1:0] f_reg [0:FB];

    always_comb
    begin
        e_next = '0;
        for (int i = 0; i < ntc_pkg::LOG_IN_W; i++)
        begin
            if (v[i])
            begin
                e_next = EW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_a_reg <= e_next;
        v_a_reg <= v;
    end

    assign v_wide = WW'(v_a_reg);

    // normalise to [1,2) in Q30
    always_ff @(posedge clk)
    begin
        if (e_a_reg <= EW'(FB))
        begin
            m_reg[0] <= MW'(v_wide << (EW'(FB) - e_a_reg));
        end
        else
        begin
            m_reg[0] <= MW'(v_wide >> (e_a_reg - EW'(FB)));
        end
        e_reg[0] <= e_a_reg;
        f_reg[0] <= '0;
    end

    for (genvar k = 1; k <= FB; k++) begin : g_sq
        logic [2*MW-1:0] prod;
        logic [MW:0]     sq;

        assign prod = (2*MW)'(m_reg[k-1]) * (2*MW)'(m_reg[k-1]);
        assign sq   = (MW+1)'(prod >> FB);

        always_ff @(posedge clk)
        begin
            if (sq[MW])
            begin
                m_reg[k] <= sq[MW:1];
            end
            else
            begin
                m_reg[k] <= sq[MW-1:0];
            end
            f_reg[k] <= {f_reg[k-1][FB-2:0], sq[MW]};
            e_reg[k] <= e_reg[k-1];
        end
    end

    assign lg = {e_reg[FB], f_reg[FB]};

endmodule

`default_nettype wire

// ----- design/ntc_mulsh.sv -----
// Pipelined signed multiply, shift by 30 toward zero, saturate, add term and saturate
`default_nettype none

module ntc_mulsh (
    input  wire logic                               clk,
    input  wire logic signed [ntc_pkg::Y_W-1:0]     a,
    input  wire logic signed [ntc_pkg::X_W-1:0]     b,
    input  wire logic signed [ntc_pkg::COEF_W-1:0]  addend,
    output logic      signed [ntc_pkg::Y_W-1:0]     y,
    output logic      signed [ntc_pkg::X_W-1:0]     b_out
);

    localparam int AW = ntc_pkg::Y_W - 1;
    localparam int BW = ntc_pkg::X_W;
    localparam int AL = 32;
    localparam int BL = 18;
    localparam int PW = 100;
    localparam int SW = PW - ntc_pkg::LOG_FB;

    logic [AW-1:0]         ua_reg;
    logic [BW-1:0]         ub_reg;
    logic                  neg1_reg, neg2_reg, neg3_reg;
    logic signed [BW-1:0]  b1_reg, b2_reg, b3_reg, b4_reg;

    logic [AL+BL-1:0]      p00_reg, p01_reg;
    logic [AW-AL+BL-1:0]   p10_reg, p11_reg;

    logic [PW-1:0]         sum;
    logic [SW-1:0]         sh;
    logic [AW-1:0]         r_reg;

    logic signed [ntc_pkg::Y_W:0] acc;
    logic signed [ntc_pkg::Y_W-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        ua_reg   <= a[ntc_pkg::Y_W-1] ? AW'(-a) : AW'(a);
        ub_reg   <= b[BW-1] ? BW'(-b) : BW'(b);
        neg1_reg <= a[ntc_pkg::Y_W-1] ^ b[BW-1];
        b1_reg   <= b;
    end

    always_ff @(posedge clk)
    begin
        p00_reg  <= (AL+BL)'(ua_reg[AL-1:0]) * (AL+BL)'(ub_reg[BL-1:0]);
        p01_reg  <= (AL+BL)'(ua_reg[AL-1:0]) * (AL+BL)'(ub_reg[BW-1:BL]);
        p10_reg  <= (AW-AL+BL)'(ua_reg[AW-1:AL]) * (AW-AL+BL)'(ub_reg[BL-1:0]);
        p11_reg  <= (AW-AL+BL)'(ua_reg[AW-1:AL]) * (AW-AL+BL)'(ub_reg[BW-1:BL]);
        neg2_reg <= neg1_reg;
        b2_reg   <= b1_reg;
    end

    assign sum = PW'(p00_reg) + (PW'(p01_reg) << BL) + (PW'(p10_reg) << AL)
               + (PW'(p11_reg) << (AL + BL));
    assign sh  = SW'(sum >> ntc_pkg::LOG_FB);

    always_ff @(posedge clk)
    begin
        if (sh > SW'(ntc_pkg::SAT_POS))
        begin
            r_reg <= AW'(ntc_pkg::SAT_POS);
        end
        else
        begin
            r_reg <= sh[AW-1:0];
        end
        neg3_reg <= neg2_reg;
        b3_reg   <= b2_reg;
    end

    assign acc = (ntc_pkg::Y_W+1)'(addend)
               + (neg3_reg ? -$signed((ntc_pkg::Y_W+1)'(r_reg))
                           : $signed((ntc_pkg::Y_W+1)'(r_reg)));

    always_ff @(posedge clk)
    begin
        priority if (acc > (ntc_pkg::Y_W+1)'(ntc_pkg::SAT_POS))
        begin
            y_reg <= ntc_pkg::SAT_POS;
        end
        else if (acc < (ntc_pkg::Y_W+1)'(ntc_pkg::SAT_NEG))
        begin
            y_reg <= ntc_pkg::SAT_NEG;
        end
        else
        begin
            y_reg <= ntc_pkg::Y_W'(acc);
        end
        b4_reg <= b3_reg;
    end

    assign y     = y_reg;
    assign b_out = b4_reg;

endmodule

`default_nettype wire

// ----- tb/tb_ntc_thermistor_to_temperature_unit.sv -----
// Self-checking testbench for the NTC thermistor temperature converter
`default_nettype none

module tb_ntc_thermistor_to_temperature_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ntc_pkg::*;

    typedef struct {
        sample_t smp;
        int      gap;
        bit      drain;
    } reading_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    sample_t          sample = '0;
    logic             result_strobe;
    result_t          result;
    logic             wr_en = 1'b0;
    reg_index_t       wr_index = REG_PULLUP;
    logic [COEF_W-1:0] wr_data = '0;

    // converter settings as the block should hold them
    logic [19:0]        pullup_r;
    logic [19:0]        nominal_r;
    logic signed [47:0] coef_r [4];
    logic [12:0]        margin_r;
    logic signed [12:0] disc_r;

    reading_t pending_readings[$];
    result_t  expected_temps[$];
    int       idle_cnt = 0;
    int       errors = 0;
    int       n_beats = 0;
    int       n_checked = 0;
    int       n_open = 0;

    ntc_thermistor_to_temperature_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .result_strobe(result_strobe), .result(result),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("timeout");
        $display("tb_ntc_thermistor_to_temperature_unit: errors");
        $finish;
    end

    // (a*b) >> 30 toward zero, magnitude limited to 2^62
    function automatic longint q30_product(longint a, longint b);
        logic [127:0]    p;
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned mag;
        bit              neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? longint'(-a) : a;
        ub = (b < 0) ? longint'(-b) : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = p >> 30;
        if (p > 128'h4000_0000_0000_0000)
            mag = 64'h4000_0000_0000_0000;
        else
            mag = p[63:0];
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint limit62(longint v);
        if (v > 64'sh4000_0000_0000_0000)
            return 64'sh4000_0000_0000_0000;
        if (v < -64'sh4000_0000_0000_0000)
            return -64'sh4000_0000_0000_0000;
        return v;
    endfunction

    function automatic longint log2_q30(longint unsigned v);
        int              e;
        int              i;
        longint unsigned m;
        longint unsigned frac;
        e = 0;
        frac = 0;
        while (e < 62 && (v >> (e + 1)) != 0)
            e++;
        m = (e <= 30) ? v << (30 - e) : v >> (e - 30);
        for (i = 0; i < 30; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (longint'(e) << 30) + longint'(frac);
    endfunction

    function automatic result_t predict_temperature(sample_t smp);
        longint          s;
        longint          vr;
        longint          thr;
        longint          x;
        longint          y;
        longint          c;
        longint          n;
        longint          r;
        longint unsigned num;
        longint unsigned den;
        longint unsigned t;
        result_t         res;
        s = longint'($signed(smp.sense_mv));
        vr = longint'(smp.vref_mv);
        thr = vr - longint'(margin_r);
        if (s <= 0 || s >= thr || pullup_r == 0 || nominal_r == 0)
        begin
            res.temperature_q4 = disc_r;
            res.open_sensor = 1'b1;
            return res;
        end
        num = longint'(pullup_r) * s;
        den = (vr - s) * longint'(nominal_r);
        x = q30_product(log2_q30(num) - log2_q30(den), 744261118);
        y = coef_r[3];
        y = limit62(coef_r[2] + q30_product(y, x));
        y = limit62(coef_r[1] + q30_product(y, x));
        y = limit62(coef_r[0] + q30_product(y, x));
        if (y < 282)
            y = 282;
        t = ((64'd1 << 58) + longint'(y) / 2) / longint'(y);
        if (t > (64'd1 << 40))
            t = 64'd1 << 40;
        c = longint'(t) * 100 - (longint'(27315) << 10);
        n = c + (longint'(50) << 6);
        r = n / 6400;
        if (n < 0 && r * 6400 != n)
            r--;
        if (r > 4095)
            r = 4095;
        if (r < -4096)
            r = -4096;
        res.temperature_q4 = r[12:0];
        res.open_sensor = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // sender: one beat per queued reading, after its drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            sample <= '0;
            idle_cnt <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_temps.push_back(predict_temperature(sample));
                n_beats++;
            end
            if (!start || !busy)
            begin
                if (pending_readings.size() != 0 && idle_cnt >= pending_readings[0].gap
                    && (!pending_readings[0].drain || expected_temps.size() == 0))
                begin
                    start <= 1'b1;
                    sample <= pending_readings[0].smp;
                    void'(pending_readings.pop_front());
                    idle_cnt <= 0;
                end
                else
                begin
                    start <= 1'b0;
                    idle_cnt <= idle_cnt + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (expected_temps.size() == 0)
                report_mismatch("unexpected beat, temperature", $signed(result.temperature_q4), 0);
            else
            begin
                if (result.temperature_q4 !== expected_temps[0].temperature_q4)
                    report_mismatch("temperature_q4", $signed(result.temperature_q4),
                                    $signed(expected_temps[0].temperature_q4));
                if (result.open_sensor !== expected_temps[0].open_sensor)
                    report_mismatch("open_sensor", result.open_sensor,
                                    expected_temps[0].open_sensor);
                if (expected_temps[0].open_sensor)
                    n_open++;
                n_checked++;
                void'(expected_temps.pop_front());
            end
        end
    end

    task automatic write_reg(reg_index_t idx, logic [47:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_PULLUP:  pullup_r = val[19:0];
            REG_NOMINAL: nominal_r = val[19:0];
            REG_COEF_A:  coef_r[0] = val;
            REG_COEF_B:  coef_r[1] = val;
            REG_COEF_C:  coef_r[2] = val;
            REG_COEF_D:  coef_r[3] = val;
            REG_MARGIN:  margin_r = val[12:0];
            REG_DISC:    disc_r = val[12:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_readings.size() != 0 || start || expected_temps.size() != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    task automatic push_reading(logic signed [15:0] s, logic [12:0] vr, int gap, bit drain);
        reading_t rd;
        rd.smp.sense_mv = s;
        rd.smp.vref_mv = vr;
        rd.gap = gap;
        rd.drain = drain;
        pending_readings.push_back(rd);
    endtask

    task automatic typical_coefs();
        write_reg(REG_COEF_A, 48'sd944060000000);
        write_reg(REG_COEF_B, 48'sd71258000000);
        write_reg(REG_COEF_C, 48'sd1000000000);
        write_reg(REG_COEF_D, 48'sd28000000);
    endtask

    // mostly well-formed readings, some full-range noise, bursts without gaps
    task automatic random_readings(int n);
        int          i;
        int          gap;
        int          burst;
        logic [12:0] vr;
        int          hi;
        burst = 0;
        for (i = 0; i < n; i++)
        begin
            if (burst == 0 && $urandom_range(0, 9) == 0)
                burst = $urandom_range(5, 25);
            gap = (burst != 0) ? 0 : $urandom_range(0, 18);
            if (burst != 0)
                burst--;
            if ($urandom_range(0, 4) == 0)
                push_reading(16'($urandom), 13'($urandom), gap, i == n / 2);
            else
            begin
                vr = 13'($urandom_range(200, 8191));
                hi = int'(vr) - int'(margin_r) - 1;
                if (hi < 1)
                    hi = 1;
                push_reading(16'($urandom_range(1, hi)), vr, gap, i == n / 2);
            end
        end
    endtask

    initial
    begin
        pullup_r = 20'd10000;
        nominal_r = 20'd10000;
        coef_r[0] = '0;
        coef_r[1] = '0;
        coef_r[2] = '0;
        coef_r[3] = '0;
        margin_r = 13'd100;
        disc_r = -13'sd4096;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero polynomial hits the floor
        push_reading(16'sd1650, 13'd3300, 0, 1'b0);
        push_reading(16'sd0, 13'd3300, 0, 1'b0);
        push_reading(-16'sd32768, 13'd3300, 0, 1'b0);
        push_reading(16'sd32767, 13'd8191, 0, 1'b0);
        push_reading(16'sd3200, 13'd3300, 0, 1'b0);
        push_reading(16'sd3199, 13'd3300, 0, 1'b0);
        wait_idle();

        typical_coefs();
        push_reading(16'sd1, 13'd8191, 0, 1'b0);
        push_reading(16'sd8090, 13'd8191, 0, 1'b0);
        push_reading(16'sd1650, 13'd3300, 3, 1'b0);
        push_reading(16'sd100, 13'd3300, 0, 1'b0);
        push_reading(16'sd3000, 13'd3300, 0, 1'b0);
        push_reading(16'sd5, 13'd0, 0, 1'b0);
        random_readings(200);
        wait_idle();

        // margin above reference, zero resistances, extreme values
        write_reg(REG_MARGIN, 48'd8191);
        write_reg(REG_DISC, 48'd4095);
        push_reading(16'sd1000, 13'd8191, 0, 1'b0);
        push_reading(16'sd10, 13'd50, 0, 1'b0);
        wait_idle();
        write_reg(REG_MARGIN, 48'd0);
        write_reg(REG_PULLUP, 48'd0);
        push_reading(16'sd1000, 13'd3300, 0, 1'b0);
        push_reading(16'sd8190, 13'd8191, 0, 1'b0);
        wait_idle();
        write_reg(REG_PULLUP, 48'd1048575);
        write_reg(REG_NOMINAL, 48'd0);
        push_reading(16'sd1000, 13'd3300, 0, 1'b0);
        wait_idle();
        write_reg(REG_NOMINAL, 48'd1);
        push_reading(16'sd8190, 13'd8191, 0, 1'b0);
        push_reading(16'sd1, 13'd8191, 0, 1'b0);
        random_readings(100);
        wait_idle();

        write_reg(REG_PULLUP, 48'd1);
        write_reg(REG_NOMINAL, 48'd1048575);
        write_reg(REG_COEF_A, 48'sh7FFF_FFFF_FFFF);
        write_reg(REG_COEF_B, 48'sh8000_0000_0000);
        write_reg(REG_COEF_C, 48'sh7FFF_FFFF_FFFF);
        write_reg(REG_COEF_D, 48'sh8000_0000_0000);
        write_reg(REG_DISC, 48'd0);
        push_reading(16'sd1, 13'd8191, 0, 1'b0);
        push_reading(16'sd8190, 13'd8191, 0, 1'b0);
        random_readings(100);
        wait_idle();

        // negative polynomial clamps to the floor
        write_reg(REG_COEF_A, -48'sd5000000000);
        write_reg(REG_COEF_B, 48'sd0);
        write_reg(REG_COEF_C, 48'sd0);
        write_reg(REG_COEF_D, 48'sd0);
        write_reg(REG_PULLUP, 48'd10000);
        write_reg(REG_NOMINAL, 48'd10000);
        write_reg(REG_MARGIN, 48'd100);
        push_reading(16'sd1650, 13'd3300, 0, 1'b0);
        wait_idle();

        typical_coefs();
        write_reg(REG_DISC, 48'(-13'sd4096));
        random_readings(200);
        wait_idle();

        // random settings
        write_reg(REG_PULLUP, 48'($urandom_range(1, 1048575)));
        write_reg(REG_NOMINAL, 48'($urandom_range(1, 1048575)));
        write_reg(REG_COEF_A, 48'({$urandom, $urandom}));
        write_reg(REG_COEF_B, 48'({$urandom, $urandom} >>> $urandom_range(0, 20)));
        write_reg(REG_COEF_C, 48'({$urandom, $urandom} >>> $urandom_range(8, 40)));
        write_reg(REG_COEF_D, 48'({$urandom, $urandom} >>> $urandom_range(8, 40)));
        write_reg(REG_MARGIN, 48'($urandom_range(0, 400)));
        write_reg(REG_DISC, 48'($urandom));
        random_readings(180);
        wait_idle();

        while (expected_temps.size() != 0)
        begin
            report_mismatch("missing beat, temperature", 0,
                            $signed(expected_temps[0].temperature_q4));
            void'(expected_temps.pop_front());
        end
        $display("%0d readings sent, %0d results checked (%0d open-sensor) across",
                 n_beats, n_checked, n_open);
        $display("reset, typical, extreme, clamped and random converter settings");
        if (errors == 0)
            $display("tb_ntc_thermistor_to_temperature_unit: clean");
        else
            $display("tb_ntc_thermistor_to_temperature_unit: errors");
        $finish;
    end

endmodule

`default_nettype wire
